// ----- design/gm3_pkg.sv -----
// Package for the 3x3 gradient magnitude unit: states, geometry constants, kernels.
// No dependencies.
`timescale 1ns / 1ps

package gm3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int DIM_W      = 11;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 14;
    localparam int SQ_W       = 24;
    localparam int SUM_W      = 25;

    localparam logic [DIM_W-1:0] DIM_MIN = 11'd3;
    localparam logic [DIM_W-1:0] W_MAX   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_MAX   = DIM_W'(MAX_HEIGHT);

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OPSEL  = 2'd2;

    // operator codes
    localparam logic [1:0] OP_SOBEL   = 2'd0;
    localparam logic [1:0] OP_SCHARR  = 2'd1;
    localparam logic [1:0] OP_LAPLACE = 2'd2;

    // kernel rows: Sobel x/y, Scharr x/y, Laplacian
    localparam logic signed [4:0] KERN [5][9] = '{
        '{-5'sd1,  5'sd0,  5'sd1, -5'sd2,  5'sd0,  5'sd2, -5'sd1,  5'sd0,  5'sd1},
        '{-5'sd1, -5'sd2, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd2,  5'sd1},
        '{-5'sd3,  5'sd0,  5'sd3, -5'sd10, 5'sd0,  5'sd10, -5'sd3, 5'sd0,  5'sd3},
        '{-5'sd3, -5'sd10, -5'sd3, 5'sd0,  5'sd0,  5'sd0,  5'sd3,  5'sd10, 5'sd3},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1}
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_START,
        ST_ROOT,
        ST_OUT
    } gm3_state_t;

    typedef struct packed {
        logic conv_en;
        logic sq_en;
    } kern_ctl_t;

endpackage

// ----- design/gradient_magnitude_3x3_unit.sv -----
// Top level of the streaming 3x3 gradient magnitude unit.
// Depends on gm3_pkg, gm3_line_mem, gm3_kernel, gm3_isqrt.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one greyscale pixel per item in raster order; s_frame_start marks
//   the first pixel of a frame and zeroes the column and row counts.
//   m_ channel: one item per interior window centre: coordinates, magnitude
//   floor(sqrt(Gx^2+Gy^2)) saturated at 255, and frame_last on the frame's final one.
//   Border pixels give no item.
//   cfg_ channel: register writes (0 width, 1 height, 2 operator), always ready;
//   write only while the unit is idle.
// Timing
//   Pixels are handled one at a time. A border pixel takes a line store read, then
//   write-back. An interior pixel goes through read, kernel sum, squares, start, the
//   bit-serial root (8 result bits, then the done step), output load.
// Reset
//   After aresetn the line stores are swept to zero, one column a cycle, across all
//   columns with s_ready low. Configuration writes are accepted throughout.
// Stall
//   The result sits in an output register; the next pixel is accepted meanwhile, and a
//   finished result waits in the output load step while that register is full, until m_ready frees it.

module gradient_magnitude_3x3_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_centre_col,
    output logic [9:0]  m_centre_row,
    output logic [7:0]  m_magnitude,
    output logic        m_frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import gm3_pkg::*;

    gm3_state_t state_reg, state_next;

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [1:0]       opsel_reg;
    logic [DIM_W-1:0] w_eff, h_eff;

    // position of the next pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             accept;

    // item in flight
    logic [COL_W-1:0] c_reg;
    logic [ROW_W-1:0] r_reg;
    logic [PIX_W-1:0] px_reg;
    logic             interior_reg, last_reg;
    logic             interior_next, last_next;

    // clearing sweep
    logic [COL_W-1:0] clr_reg;

    // window: [row*2] column c-2, [row*2+1] column c-1
    logic [PIX_W-1:0] win_reg [6];
    logic [PIX_W-1:0] pix [9];

    // memory
    logic             mem_rd_en, mem_wr_en;
    logic [COL_W-1:0] mem_wr_addr;
    logic [PIX_W-1:0] mem_wr_upper, mem_wr_middle;
    logic [PIX_W-1:0] rd_upper, rd_middle;

    kern_ctl_t        kctl;
    logic [SUM_W-1:0] sum_sq;
    logic             sq_start, sq_done;
    logic [7:0]       sq_root;
    logic             out_load;

    logic             m_valid_reg;
    logic [9:0]       m_col_reg, m_row_reg;
    logic [7:0]       m_mag_reg;
    logic             m_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
            opsel_reg  <= OP_SOBEL;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_OPSEL:  opsel_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (width_reg < DIM_MIN) ? DIM_MIN : (width_reg > W_MAX) ? W_MAX : width_reg;
    assign h_eff = (height_reg < DIM_MIN) ? DIM_MIN :
                   (height_reg > H_MAX) ? H_MAX : height_reg;

    assign accept  = s_valid && s_ready;
    assign cur_col = s_frame_start ? '0 : col_reg;
    assign cur_row = s_frame_start ? '0 : row_reg;

    always_comb begin
        interior_next = (cur_col >= COL_W'(2)) && (cur_row >= ROW_W'(2)) &&
                        ({1'b0, cur_col} < w_eff) && ({1'b0, cur_row} < h_eff);
        last_next     = ({1'b0, cur_col} == w_eff - 11'd1) &&
                        ({1'b0, cur_row} == h_eff - 11'd1);
        if (({1'b0, cur_col} + 11'd1) >= w_eff) begin
            col_next = '0;
            row_next = (({1'b0, cur_row} + 11'd1) >= h_eff) ? '0 : cur_row + ROW_W'(1);
        end else begin
            col_next = cur_col + COL_W'(1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            c_reg        <= cur_col;
            r_reg        <= cur_row;
            px_reg       <= s_pixel;
            interior_reg <= interior_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_reg <= clr_reg + COL_W'(1);
        end
    end

    // window shifts once per pixel, at the write-back cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (state_reg == ST_READ) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= rd_upper;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= rd_middle;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= px_reg;
        end
    end

    always_comb begin
        pix[0] = win_reg[0];
        pix[1] = win_reg[1];
        pix[2] = rd_upper;
        pix[3] = win_reg[2];
        pix[4] = win_reg[3];
        pix[5] = rd_middle;
        pix[6] = win_reg[4];
        pix[7] = win_reg[5];
        pix[8] = px_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid) state_next = ST_READ;
            ST_READ:   state_next = interior_reg ? ST_SQUARE : ST_IDLE;
            ST_SQUARE: state_next = ST_START;
            ST_START:  state_next = ST_ROOT;
            ST_ROOT:   if (sq_done) state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // outputs of the sequencer
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        mem_rd_en     = (state_reg == ST_IDLE);
        mem_wr_en     = 1'b0;
        mem_wr_addr   = c_reg;
        mem_wr_upper  = rd_middle;
        mem_wr_middle = px_reg;
        kctl.conv_en  = 1'b0;
        kctl.sq_en    = 1'b0;
        sq_start      = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_reg;
                mem_wr_upper  = '0;
                mem_wr_middle = '0;
            end
            ST_READ: begin
                mem_wr_en    = 1'b1;
                kctl.conv_en = 1'b1;
            end
            ST_SQUARE: kctl.sq_en = 1'b1;
            ST_START:  sq_start = 1'b1;
            ST_OUT:    out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    gm3_line_mem u_mem (
        .aclk      (aclk),
        .rd_en     (mem_rd_en),
        .rd_addr   (cur_col),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_upper  (mem_wr_upper),
        .wr_middle (mem_wr_middle),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    gm3_kernel u_kernel (
        .aclk   (aclk),
        .ctl    (kctl),
        .op_sel (opsel_reg),
        .pix    (pix),
        .sum_sq (sum_sq)
    );

    gm3_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sum_sq),
        .done     (sq_done),
        .root     (sq_root)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_col_reg  <= c_reg - COL_W'(1);
            m_row_reg  <= r_reg - ROW_W'(1);
            m_mag_reg  <= sq_root;
            m_last_reg <= last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_centre_col = m_col_reg;
    assign m_centre_row = m_row_reg;
    assign m_magnitude  = m_mag_reg;
    assign m_frame_last = m_last_reg;

`ifndef SYNTHESIS
    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output load");
    a_interior_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_centre_col != 10'd0) && (m_centre_row != 10'd0))
        else $error("border coordinate on result");
    a_root_done_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> (state_reg == ST_ROOT))
        else $error("square root finished out of step");
`endif

endmodule

// ----- design/gm3_line_mem.sv -----
// Two line stores (rows r-2 and r-1), one write and one registered read per cycle.
// Depends on gm3_pkg.
`timescale 1ns / 1ps

module gm3_line_mem (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [gm3_pkg::COL_W-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [gm3_pkg::COL_W-1:0] wr_addr,
    input  logic [gm3_pkg::PIX_W-1:0] wr_upper,
    input  logic [gm3_pkg::PIX_W-1:0] wr_middle,
    output logic [gm3_pkg::PIX_W-1:0] rd_upper,
    output logic [gm3_pkg::PIX_W-1:0] rd_middle
);
    import gm3_pkg::*;

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_upper  <= upper_mem[rd_addr];
            rd_middle <= middle_mem[rd_addr];
        end
    end

endmodule

// ----- design/gm3_kernel.sv -----
// Kernel pair sums and their squares, two register stages.
// Depends on gm3_pkg.
`timescale 1ns / 1ps

module gm3_kernel (
    input  logic                      aclk,
    input  gm3_pkg::kern_ctl_t        ctl,
    input  logic [1:0]                op_sel,
    input  logic [gm3_pkg::PIX_W-1:0] pix [9],
    output logic [gm3_pkg::SUM_W-1:0] sum_sq
);
    import gm3_pkg::*;

    logic signed [GRAD_W-1:0] acc [5];
    logic signed [GRAD_W-1:0] gx_next, gy_next;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic signed [27:0]       gx_w, gy_w, px2, py2;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;

    // constant coefficients, so each term folds to shifts and adds
    always_comb begin
        for (int k = 0; k < 5; k++) begin
            acc[k] = '0;
            for (int i = 0; i < 9; i++) begin
                acc[k] = acc[k] + GRAD_W'($signed({6'b0, pix[i]}))
                                  * GRAD_W'(KERN[k][i]);
            end
        end
    end

    always_comb begin
        case (op_sel)
            OP_SCHARR: begin
                gx_next = acc[2];
                gy_next = acc[3];
            end
            OP_LAPLACE: begin
                gx_next = acc[4];
                gy_next = acc[4];
            end
            default: begin
                gx_next = acc[0];
                gy_next = acc[1];
            end
        endcase
    end

    assign gx_w = 28'(gx_reg);
    assign gy_w = 28'(gy_reg);
    assign px2  = gx_w * gx_w;
    assign py2  = gy_w * gy_w;

    always_ff @(posedge aclk) begin
        if (ctl.conv_en) begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (ctl.sq_en) begin
            sqx_reg <= px2[SQ_W-1:0];
            sqy_reg <= py2[SQ_W-1:0];
        end
    end

    assign sum_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};

endmodule

// ----- design/gm3_isqrt.sv -----
// Bit-serial floor square root, one result bit per cycle, saturating at 255.
// Depends on gm3_pkg.
`timescale 1ns / 1ps

module gm3_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [gm3_pkg::SUM_W-1:0] radicand,
    output logic                      done,
    output logic [7:0]                root
);
    import gm3_pkg::*;

    logic [SUM_W-1:0] rad_reg;
    logic [7:0]       root_reg, trial;
    logic [2:0]       idx_reg;
    logic             run_reg, done_reg;
    logic [15:0]      trial_sq;

    assign trial    = root_reg | (8'd1 << idx_reg);
    assign trial_sq = 16'(trial) * 16'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= run_reg && (idx_reg == 3'd0);
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && idx_reg == 3'd0) begin
                run_reg <= 1'b0;
            end
        end
    end

    // eight bits only, so a radicand at or above 255^2 lands on 255
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            root_reg <= '0;
            idx_reg  <= 3'd7;
        end else if (run_reg) begin
            if ({9'b0, trial_sq} <= rad_reg) begin
                root_reg <= trial;
            end
            idx_reg <= idx_reg - 3'd1;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
